// File: hdl/seu_pkg.sv
// Package for the sequence event unpacker: request/response structs, decoder state,
// limits and byte codes.
// No dependencies.
`default_nettype none

package seu_pkg;

   // Limits of one sequence
   localparam int MAX_EVENTS       = 1024;
   localparam int MAX_PACKED_BYTES = 256;
   localparam int EV_W             = $clog2(MAX_EVENTS + 1);
   localparam int BYTES_W          = $clog2(MAX_PACKED_BYTES + 1);

   // Byte codes
   localparam logic [7:0] END_MARK  = 8'h7f;
   localparam logic [7:0] CMD_MIN   = 8'hc0;
   localparam logic [7:0] INST_MIN  = 8'ha0;
   localparam logic [7:0] NO_BYTE   = 8'h80;
   localparam logic [7:0] TIE_INST  = 8'h90;
   localparam logic [7:0] NONE_NUM  = 8'hff;
   localparam logic [6:0] HELD_NOTE = 7'h7e;
   localparam logic [6:0] OFF_NOTE  = 7'h00;

   // Response kinds
   localparam logic [1:0] KIND_EVENT = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] KIND_LIMIT = 2'd3;

   // Position of the next byte within an event
   typedef enum logic [1:0] {
      STG_START,
      STG_CMD,
      STG_INST,
      STG_DUR
   } stage_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_sequence;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] command_byte;
      logic [7:0] instrument_byte;
      logic [6:0] note_byte;
      logic [9:0] event_slot;
      logic       last_of_run;
      logic [8:0] packed_size;
      logic [7:0] last_command;
      logic [7:0] last_instrument;
   } rsp_type;

   typedef struct packed {
      stage_type          stage;
      logic [7:0]         pend_cmd;
      logic [7:0]         pend_ins;
      logic [3:0]         held_dur;
      logic [EV_W-1:0]    events;
      logic [BYTES_W-1:0] bytes;
      logic [7:0]         latest_cmd;
      logic [7:0]         latest_ins;
      logic               finished;
      logic               in_fill;    // emitting duration fillers
      logic [3:0]         fill_left;  // fillers still to go
      logic               fill_note;  // filler is held note, else off
   } dec_state_type;

   localparam dec_state_type DEC_RESET = '{
      stage:      STG_START,
      pend_cmd:   NO_BYTE,
      pend_ins:   NO_BYTE,
      held_dur:   4'd0,
      events:     '0,
      bytes:      '0,
      latest_cmd: NONE_NUM,
      latest_ins: NONE_NUM,
      finished:   1'b0,
      in_fill:    1'b0,
      fill_left:  4'd0,
      fill_note:  1'b0
   };

   // One step of the decoder
   typedef struct packed {
      logic          has_result;
      logic          done;       // held byte fully handled
      rsp_type       rsp;
      dec_state_type next;
   } step_type;

   // Engine status toward the top level
   typedef struct packed {
      logic hold_valid;
      logic in_fill;
   } eng_status_type;

endpackage

`default_nettype wire

// File: hdl/seu_step.sv
// Combinational step of the unpacker: handles the held byte (or one filler)
// against the decoder state. Depends on seu_pkg.
`default_nettype none

module seu_step
   import seu_pkg::*;
(
   input  dec_state_type cur,
   input  req_type       req,
   output step_type      step
);

   dec_state_type s;
   dec_state_type n;
   logic          stat;
   logic [1:0]    stat_kind;
   logic          prefix;
   logic [7:0]    b;

   always_comb begin
      // Start of sequence clears state before the byte is seen, unless fillers are pending
      s = cur;
      if (!cur.in_fill && req.start_of_sequence) begin
         s = DEC_RESET;
      end
      n         = s;
      b         = req.data_byte;
      stat      = 1'b0;
      stat_kind = KIND_ERROR;
      prefix    = 1'b0;

      step.has_result           = 1'b0;
      step.done                 = 1'b1;
      step.rsp.result_kind      = KIND_EVENT;
      step.rsp.command_byte     = NO_BYTE;
      step.rsp.instrument_byte  = NO_BYTE;
      step.rsp.note_byte        = OFF_NOTE;
      step.rsp.event_slot       = 10'(s.events);
      step.rsp.last_of_run      = 1'b0;
      step.rsp.packed_size      = 9'd0;

      if (s.in_fill) begin
         // Duration filler
         if (s.events >= EV_W'(MAX_EVENTS)) begin
            stat = 1'b1;
         end else begin
            step.has_result       = 1'b1;
            step.rsp.note_byte    = s.fill_note ? HELD_NOTE : OFF_NOTE;
            n.events              = s.events + 1'b1;
            n.fill_left           = s.fill_left - 4'd1;
            if (s.fill_left == 4'd1) begin
               step.rsp.last_of_run = 1'b1;
               n.in_fill            = 1'b0;
               n.pend_cmd           = NO_BYTE;
               n.pend_ins           = NO_BYTE;
               n.stage              = STG_START;
            end else begin
               step.done = 1'b0;
            end
         end
      end else if (s.finished) begin
         // Sequence over: byte dropped
         step.has_result = 1'b0;
      end else if (s.bytes >= BYTES_W'(MAX_PACKED_BYTES)) begin
         stat      = 1'b1;
         stat_kind = KIND_LIMIT;
      end else begin
         n.bytes = s.bytes + 1'b1;
         if (s.stage == STG_START && b == END_MARK) begin
            stat      = 1'b1;
            stat_kind = KIND_END;
         end else if (s.stage == STG_START && b >= CMD_MIN) begin
            n.pend_cmd   = b;
            n.latest_cmd = {2'b00, b[5:0]};
            n.stage      = STG_CMD;
            prefix       = 1'b1;
         end else if ((s.stage == STG_START || s.stage == STG_CMD) && b >= INST_MIN) begin
            n.pend_ins   = b;
            n.latest_ins = {3'b000, b[4:0]};
            n.stage      = STG_INST;
            prefix       = 1'b1;
         end else if (s.stage != STG_DUR && b[7]) begin
            n.held_dur = b[3:0];
            if (b[4]) begin
               n.pend_ins = TIE_INST;
            end
            n.stage = STG_DUR;
            prefix  = 1'b1;
         end else if (b[7]) begin
            // Bad note byte
            stat = 1'b1;
         end else if (s.events >= EV_W'(MAX_EVENTS)) begin
            stat = 1'b1;
         end else begin
            // Note event
            step.has_result          = 1'b1;
            step.rsp.command_byte    = s.pend_cmd;
            step.rsp.instrument_byte = s.pend_ins;
            step.rsp.note_byte       = b[6:0];
            n.events                 = s.events + 1'b1;
            if (s.held_dur == 4'd0) begin
               step.rsp.last_of_run = 1'b1;
               n.pend_cmd           = NO_BYTE;
               n.pend_ins           = NO_BYTE;
               n.stage              = STG_START;
            end else begin
               n.in_fill   = 1'b1;
               n.fill_left = s.held_dur;
               n.fill_note = (b[6:0] != OFF_NOTE);
               step.done   = 1'b0;
            end
         end
         // Prefix took the last allowed byte: event cannot complete
         if (prefix && n.bytes >= BYTES_W'(MAX_PACKED_BYTES)) begin
            stat = 1'b1;
         end
      end

      // Status response ends the sequence
      if (stat) begin
         step.has_result          = 1'b1;
         step.done                = 1'b1;
         step.rsp.result_kind     = stat_kind;
         step.rsp.command_byte    = NO_BYTE;
         step.rsp.instrument_byte = NO_BYTE;
         step.rsp.note_byte       = OFF_NOTE;
         step.rsp.event_slot      = 10'(n.events);
         step.rsp.packed_size     = 9'(n.bytes);
         step.rsp.last_of_run     = 1'b1;
         n.finished               = 1'b1;
         n.in_fill                = 1'b0;
      end

      step.rsp.last_command    = n.latest_cmd;
      step.rsp.last_instrument = n.latest_ins;
      step.next                = n;
   end

endmodule

`default_nettype wire

// File: hdl/seu_engine.sv
// Unpacker engine: input register, decoder state registers and the step logic.
// Depends on seu_pkg and seu_step.
`default_nettype none

module seu_engine
   import seu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  req_type        req,
   output logic           req_ready,
   input  logic           out_free,
   output logic           res_valid,
   output rsp_type        res,
   output eng_status_type status
);

   logic          hold_valid_ff;
   logic          hold_valid_in;
   req_type       hold_ff;
   dec_state_type st_ff;
   dec_state_type st_in;
   step_type      step;
   logic          fire;
   logic          req_fire;

   seu_step u_step (
      .cur  (st_ff),
      .req  (hold_ff),
      .step (step)
   );

   // Advance when the step has no response or the output can take it
   assign fire      = hold_valid_ff && (!step.has_result || out_free);
   assign req_ready = !hold_valid_ff || (fire && step.done);
   assign req_fire  = req_valid && req_ready;
   assign res_valid = fire && step.has_result;
   assign res       = step.rsp;

   // Next values
   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_fire) begin
         hold_valid_in = 1'b1;
      end else if (fire && step.done) begin
         hold_valid_in = 1'b0;
      end
      st_in = fire ? step.next : st_ff;
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         st_ff         <= DEC_RESET;
      end else begin
         hold_valid_ff <= hold_valid_in;
         st_ff         <= st_in;
      end
   end

   // Held request payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         hold_ff <= req;
      end
   end

   assign status.hold_valid = hold_valid_ff;
   assign status.in_fill    = st_ff.in_fill;

endmodule

`default_nettype wire

// File: hdl/seu_rsp_reg.sv
// Response output register with valid/ready handshake.
// Depends on seu_pkg.
`default_nettype none

module seu_rsp_reg
   import seu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type data,
   output logic    free,
   output logic    rsp_valid,
   output rsp_type rsp,
   input  logic    rsp_ready
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Register can take a new response when empty or draining
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

`default_nettype wire

// File: hdl/sequence_event_unpacker_unit.sv
// Sequence event unpacker, top level. An accepted request is held in the input
// register; its responses pass through the single output register. A note byte
// holds the input register while its duration fillers go out, one response per
// cycle when the output register is free; a new byte is taken as it completes.
// Reset: synchronous, active high; clears handshake and decoder state at once.
// Depends on seu_pkg, seu_engine, seu_rsp_reg.
`default_nettype none

module sequence_event_unpacker_unit
   import seu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic           out_free;
   logic           res_valid;
   rsp_type        res;
   eng_status_type eng_status;

   seu_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req       (req),
      .req_ready (req_ready),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res       (res),
      .status    (eng_status)
   );

   seu_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .data      (res),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .rsp_ready (rsp_ready)
   );

   // Status responses always close the run of their byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.result_kind != KIND_EVENT |-> rsp.last_of_run)
      else $error("status response without last_of_run");

   // Event responses carry no packed size
   a_event_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.result_kind == KIND_EVENT |-> rsp.packed_size == 9'd0)
      else $error("event response with nonzero packed size");

   // Input held back only while a byte is in work
   a_ready_hold: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> eng_status.hold_valid)
      else $error("request stalled with empty input register");

   // Filler emission belongs to a held byte
   a_fill_hold: assert property (@(posedge clock) disable iff (reset)
      eng_status.in_fill |-> eng_status.hold_valid)
      else $error("filler pending without held byte");

endmodule

`default_nettype wire
